>>> design/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion block.
// Used by the front stage, the square-root cells and the top level.
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int ELEM_W        = 16;
   localparam int NUM_ELEMS     = 9;
   localparam int NUM_LANES     = 4;
   localparam int REQ_DATA_W    = 144;
   localparam int RSP_DATA_W    = 64;
   localparam int QUAT_W_W      = 15;
   localparam int QUAT_V_W      = 16;

   // Lane numbers inside the square-root chain.
   localparam int LANE_W = 0;
   localparam int LANE_X = 1;
   localparam int LANE_Y = 2;
   localparam int LANE_Z = 3;

   localparam logic [QUAT_W_W-1:0] W_MAX       = 15'h7FFF;
   localparam logic [QUAT_V_W-1:0] S_MAX       = 16'h7FFF;
   localparam logic [QUAT_V_W-1:0] S_MIN       = 16'h8000;
   localparam int unsigned         S_MAX_MAG   = 32767;
   localparam int unsigned         S_MIN_MAG   = 32768;

   // Sign handling of the vector part: bit 0 is x, bit 1 is y, bit 2 is z.
   typedef struct packed {
      logic [2:0] neg;
      logic [2:0] zero;
   } sign_flags_type;

endpackage

>>> design/rmq_front.sv
// Input stage: forms the four trace combinations, their magnitudes and the
// sign flags of the off-diagonal differences. Depends on rmq_pkg.
module rmq_front
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int A_W       = 18,
   parameter int RW        = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [REQ_DATA_W-1:0]              in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [NUM_LANES-1:0][RW-1:0]       rad_o,
   output sign_flags_type                     flags_o
);

   localparam int SW = A_W + 1;
   localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

   logic [NUM_ELEMS-1:0][SW-1:0] e;
   logic [NUM_LANES-1:0][SW-1:0] s;
   logic [NUM_LANES-1:0][A_W-1:0] a;
   logic [ELEM_W:0] dx, dy, dz;

   logic                          valid_ff, valid_in;
   logic [NUM_LANES-1:0][RW-1:0]  rad_ff, rad_in;
   sign_flags_type                flags_ff, flags_in;
   logic                          load;

   always_comb begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
         e[i] = {{(SW-ELEM_W){in_data[i*ELEM_W+ELEM_W-1]}}, in_data[i*ELEM_W +: ELEM_W]};
      end
   end

   // Element order: m11 m12 m13 m21 m22 m23 m31 m32 m33.
   assign s[LANE_W] = ONE_S + e[0] + e[4] + e[8];
   assign s[LANE_X] = ONE_S + e[0] - e[4] - e[8];
   assign s[LANE_Y] = ONE_S - e[0] + e[4] - e[8];
   assign s[LANE_Z] = ONE_S - e[0] - e[4] + e[8];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         a[l]      = s[l][SW-1] ? A_W'(~s[l] + SW'(1)) : s[l][A_W-1:0];
         rad_in[l] = RW'({a[l], {FRAC_BITS{1'b0}}});
      end
   end

   assign dx = e[7][ELEM_W:0] - e[5][ELEM_W:0];
   assign dy = e[2][ELEM_W:0] - e[6][ELEM_W:0];
   assign dz = e[3][ELEM_W:0] - e[1][ELEM_W:0];

   // A positive difference gives a negative component.
   always_comb begin
      flags_in.zero = {dz == '0, dy == '0, dx == '0};
      flags_in.neg  = {!dz[ELEM_W] && (dz != '0),
                       !dy[ELEM_W] && (dy != '0),
                       !dx[ELEM_W] && (dx != '0)};
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff   <= rad_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign rad_o     = rad_ff;
   assign flags_o   = flags_ff;

endmodule

>>> design/rmq_cell.sv
// One square-root cell: settles one root bit for each of the four lanes and
// hands the shifted radicand, remainder and partial root on. Depends on rmq_pkg.
module rmq_cell
   import rmq_pkg::*;
#(
   parameter int RW     = 32,
   parameter int ROOT_W = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  valid_i,
   output logic                                  ready_o,
   input  logic [NUM_LANES-1:0][RW-1:0]          rad_i,
   input  logic [NUM_LANES-1:0][ROOT_W+1:0]      rem_i,
   input  logic [NUM_LANES-1:0][ROOT_W-1:0]      root_i,
   input  sign_flags_type                        flags_i,
   output logic                                  valid_o,
   input  logic                                  ready_i,
   output logic [NUM_LANES-1:0][RW-1:0]          rad_o,
   output logic [NUM_LANES-1:0][ROOT_W+1:0]      rem_o,
   output logic [NUM_LANES-1:0][ROOT_W-1:0]      root_o,
   output sign_flags_type                        flags_o
);

   localparam int REM_W = ROOT_W + 2;

   logic                                valid_ff, valid_in;
   logic [NUM_LANES-1:0][RW-1:0]        rad_ff, rad_in;
   logic [NUM_LANES-1:0][REM_W-1:0]     rem_ff, rem_in;
   logic [NUM_LANES-1:0][ROOT_W-1:0]    root_ff, root_in;
   sign_flags_type                      flags_ff;
   logic [NUM_LANES-1:0][REM_W-1:0]     rem_t, trial;
   logic                                load;

   // Restoring square root: bring in the next two radicand bits and try
   // to subtract 4*root + 1.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         rem_t[l] = {rem_i[l][ROOT_W-1:0], rad_i[l][RW-1:RW-2]};
         trial[l] = {root_i[l], 2'b01};
         rad_in[l] = {rad_i[l][RW-3:0], 2'b00};
         if (rem_t[l] >= trial[l]) begin
            rem_in[l]  = rem_t[l] - trial[l];
            root_in[l] = {root_i[l][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[l]  = rem_t[l];
            root_in[l] = {root_i[l][ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign ready_o = !valid_ff || ready_i;
   assign load    = valid_i && ready_o;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (ready_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff   <= rad_in;
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         flags_ff <= flags_i;
      end
   end

   assign valid_o = valid_ff;
   assign rad_o   = rad_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign flags_o = flags_ff;

endmodule

>>> design/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, top level: front stage, a chain of
// square-root cells and the saturating output register.
// Depends on rmq_pkg, rmq_front and rmq_cell.
//
// Usage:
//   The req channel carries one 3x3 matrix per transfer, nine signed Q2.14
//   elements. The rsp channel returns one quaternion per matrix, in order.
//   Each result is half the truncated square root of the magnitude of a
//   trace combination; x, y and z carry the negated sign of their
//   off-diagonal difference, are zero when it is zero, and all parts
//   saturate to their field range.
//   Each result passes the front register, N square-root cells, one per
//   root bit, where N = (max(FRAC_BITS, 17) + 1 + FRAC_BITS + 1) / 2,
//   and the saturating output register.
//   Throughput is one matrix per cycle while the receiver keeps up:
//   every cell takes a new item each cycle, four lanes side by side.
//   When the receiver stalls, each stage holds its item and req_tready
//   drops only once every stage up to the input is full; empty stages
//   still take new matrices meanwhile.
//   Reset clears every valid flag, so the pipeline comes up empty.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // m11, m12, m13, m21, m22, m23, m31, m32, m33, 16 bits each
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // quat_w (15), quat_x (16), quat_y (16), quat_z (16), one zero pad bit
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int A_W     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
   localparam int N_CELLS = (A_W + FRAC_BITS + 1) / 2;
   localparam int RW      = 2 * N_CELLS;
   localparam int ROOT_W  = N_CELLS;
   localparam int MAG_W   = ROOT_W - 1;
   localparam int CMP_W   = (MAG_W > 17) ? MAG_W : 17;

   logic [N_CELLS:0]                            cvalid;
   logic [N_CELLS:0]                            cready;
   logic [N_CELLS:0][NUM_LANES-1:0][RW-1:0]     crad;
   logic [N_CELLS:0][NUM_LANES-1:0][ROOT_W+1:0] crem;
   logic [N_CELLS:0][NUM_LANES-1:0][ROOT_W-1:0] croot;
   sign_flags_type                              cflags [0:N_CELLS];

   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]               rsp_tdata_ff, rsp_tdata_in;
   logic                                out_ready;
   logic [NUM_LANES-1:0][CMP_W-1:0]     mag;
   logic [QUAT_W_W-1:0]                 w_sat;
   logic [2:0][QUAT_V_W-1:0]            v_sat;

   rmq_front #(
      .FRAC_BITS (FRAC_BITS),
      .A_W       (A_W),
      .RW        (RW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (cvalid[0]),
      .out_ready (cready[0]),
      .rad_o     (crad[0]),
      .flags_o   (cflags[0])
   );

   assign crem[0]  = '0;
   assign croot[0] = '0;

   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      rmq_cell #(
         .RW     (RW),
         .ROOT_W (ROOT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (cvalid[k]),
         .ready_o (cready[k]),
         .rad_i   (crad[k]),
         .rem_i   (crem[k]),
         .root_i  (croot[k]),
         .flags_i (cflags[k]),
         .valid_o (cvalid[k+1]),
         .ready_i (cready[k+1]),
         .rad_o   (crad[k+1]),
         .rem_o   (crem[k+1]),
         .root_o  (croot[k+1]),
         .flags_o (cflags[k+1])
      );
   end

   assign out_ready       = !rsp_tvalid_ff || rsp_tready;
   assign cready[N_CELLS] = out_ready;

   // The root carries one extra fraction bit; dropping it halves the value.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         mag[l] = CMP_W'(croot[N_CELLS][l][ROOT_W-1:1]);
      end
      w_sat = (mag[LANE_W] > CMP_W'(W_MAX)) ? W_MAX : mag[LANE_W][QUAT_W_W-1:0];
      for (int v = 0; v < 3; v++) begin
         if (cflags[N_CELLS].zero[v]) begin
            v_sat[v] = '0;
         end else if (cflags[N_CELLS].neg[v]) begin
            v_sat[v] = (mag[v+1] > CMP_W'(S_MIN_MAG)) ? S_MIN :
                       QUAT_V_W'(~mag[v+1][QUAT_V_W-1:0] + QUAT_V_W'(1));
         end else begin
            v_sat[v] = (mag[v+1] > CMP_W'(S_MAX_MAG)) ? S_MAX :
                       mag[v+1][QUAT_V_W-1:0];
         end
      end
      rsp_tdata_in = {1'b0, v_sat[2], v_sat[1], v_sat[0], w_sat};
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cvalid[N_CELLS] && out_ready) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cvalid[N_CELLS] && out_ready) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   // An accepted matrix is always held by the front stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> cvalid[0])
      else $error("accepted matrix missing from front stage");

   // A result only appears when the last cell held an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(cvalid[N_CELLS]))
      else $error("result appeared without a finished item");

   // The output comes out of reset empty.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid_ff)
      else $error("result valid right after reset");
`endif

endmodule

>>> bench/rotation_matrix_to_quaternion_test.sv
// Self-checking bench for rotation_matrix_to_quaternion: a table of directed
// matrices, then random ones, both streamed with random gaps and stalls.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
module rotation_matrix_to_quaternion_test
   import rmq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_MATRICES = 1635;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 40;

   // Handy element values in Q2.14.
   localparam logic [15:0] P1 = 16'h4000;
   localparam logic [15:0] N1 = 16'hC000;
   localparam logic [15:0] MX = 16'h7FFF;
   localparam logic [15:0] MN = 16'h8000;
   localparam logic [15:0] Z  = 16'h0000;

   typedef struct packed {
      logic [QUAT_W_W-1:0] w;
      logic [QUAT_V_W-1:0] x;
      logic [QUAT_V_W-1:0] y;
      logic [QUAT_V_W-1:0] z;
   } quat_type;

   typedef struct packed {
      logic [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
      bit          known;
      quat_type    q;
   } dir_row_type;

   // Rows with known set carry a quaternion typed in by hand; the others
   // are checked against the predictor.
   localparam int DIR_ROWS = 15;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{P1, Z,  Z,  Z,  P1, Z,  Z,  Z,  P1, 1'b1, '{15'd16384, 16'd0, 16'd0, 16'd0}},
      '{Z,  Z,  Z,  Z,  Z,  Z,  Z,  Z,  Z,  1'b1, '{15'd8192,  16'd0, 16'd0, 16'd0}},
      '{P1, Z,  Z,  Z,  N1, Z,  Z,  Z,  N1, 1'b1, '{15'd0,     16'd0, 16'd0, 16'd0}},
      '{MX, MX, MX, MX, MX, MX, MX, MX, MX, 1'b0, '0},
      '{MN, MN, MN, MN, MN, MN, MN, MN, MN, 1'b0, '0},
      '{MX, MN, MN, MN, MX, MN, MN, MN, MX, 1'b0, '0},
      '{MX, MN, MX, MX, MX, MN, MN, MX, MX, 1'b0, '0},
      '{MN, MX, MN, MN, MN, MX, MX, MN, MN, 1'b0, '0},
      '{Z,  N1, Z,  P1, Z,  Z,  Z,  Z,  P1, 1'b0, '0},
      '{P1, Z,  Z,  Z,  Z,  N1, Z,  P1, Z,  1'b0, '0},
      '{Z,  Z,  P1, Z,  P1, Z,  N1, Z,  Z,  1'b0, '0},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
        16'h5555, 16'hAAAA, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
        16'hAAAA, 16'h5555, 1'b0, '0},
      '{Z, 16'h0001, Z, Z, Z, 16'h0001, 16'hFFFF, Z, Z, 1'b0, '0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   quat_type quat_queue [$];
   int    matrices_sent = 0;
   int    quats_checked = 0;
   int    mismatch_count = 0;
   int    idle_cycles = 0;
   int    ready_left = 0;
   bit    gaps_on = 1'b1;

   rotation_matrix_to_quaternion dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Integer square root, rounded down.
   function automatic longint unsigned root_floor(longint unsigned num);
      longint unsigned res = 0;
      longint unsigned step = 64'd1 << 62;
      while (step > num)
         step >>= 2;
      while (step != 0) begin
         if (num >= res + step) begin
            num -= res + step;
            res = (res >> 1) + step;
         end else begin
            res >>= 1;
         end
         step >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned half_root(longint s);
      longint unsigned a;
      a = (s < 0) ? longint'(-s) : longint'(s);
      return root_floor(a << FRAC_BITS_DEF) >> 1;
   endfunction

   // The vector part takes the opposite sign of its off-diagonal difference.
   function automatic logic [QUAT_V_W-1:0] vector_part(longint comb, longint diff);
      longint unsigned mag;
      mag = half_root(comb);
      if (diff == 0)
         return '0;
      else if (diff > 0)
         return (mag > S_MIN_MAG) ? S_MIN : 16'(-longint'(mag));
      else
         return (mag > S_MAX_MAG) ? S_MAX : mag[15:0];
   endfunction

   function automatic quat_type quaternion_of(logic [REQ_DATA_W-1:0] d);
      longint          m [NUM_ELEMS];
      longint          one;
      longint unsigned wmag;
      quat_type        q;
      one = longint'(1) << FRAC_BITS_DEF;
      for (int i = 0; i < NUM_ELEMS; i++)
         m[i] = longint'($signed(d[ELEM_W*i +: ELEM_W]));
      wmag = half_root(one + m[0] + m[4] + m[8]);
      q.w = (wmag > 64'(W_MAX)) ? W_MAX : wmag[QUAT_W_W-1:0];
      q.x = vector_part(one + m[0] - m[4] - m[8], m[7] - m[5]);
      q.y = vector_part(one - m[0] + m[4] - m[8], m[2] - m[6]);
      q.z = vector_part(one - m[0] - m[4] + m[8], m[3] - m[1]);
      return q;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on quaternion %0d, %s: got %h, want %h",
               quats_checked, what, got, want);
      mismatch_count++;
   endtask

   // Presents one matrix, waits for its transfer, records the expected
   // quaternion, then maybe leaves a gap before the next one.
   task automatic send_matrix(input logic [REQ_DATA_W-1:0] d, input bit known,
                              input quat_type want);
      int r;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      quat_queue.push_back(known ? want : quaternion_of(d));
      matrices_sent++;
      r = $urandom_range(0, 99);
      if (gaps_on && r >= 55) begin
         req_tvalid <= 1'b0;
         if (r < 90)
            repeat ($urandom_range(1, 3)) @(posedge clock);
         else
            repeat ($urandom_range(8, 40)) @(posedge clock);
      end
   endtask

   // Receiver: runs of ready, short stalls and the odd long one.
   always @(posedge clock) begin
      int r;
      if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            rsp_tready <= 1'b1;
            ready_left <= $urandom_range(0, 20);
         end else if (r < 90) begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(15, 60);
         end
      end
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      quat_type want;
      quat_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            // The bus carries quat_w in the lowest bits, quat_z in the highest.
            got = {rsp_tdata[14:0], rsp_tdata[30:15], rsp_tdata[46:31],
                   rsp_tdata[62:47]};
            if (quat_queue.size() == 0) begin
               report_mismatch("result with none expected", rsp_tdata, '0);
            end else begin
               want = quat_queue.pop_front();
               if (got.w !== want.w)
                  report_mismatch("quat_w", 64'(got.w), 64'(want.w));
               if (got.x !== want.x)
                  report_mismatch("quat_x", 64'(got.x), 64'(want.x));
               if (got.y !== want.y)
                  report_mismatch("quat_y", 64'(got.y), 64'(want.y));
               if (got.z !== want.z)
                  report_mismatch("quat_z", 64'(got.z), 64'(want.z));
               if (rsp_tdata[63] !== 1'b0)
                  report_mismatch("pad bit", 64'(rsp_tdata[63]), '0);
            end
            quats_checked++;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] e [NUM_ELEMS];
      logic [15:0] specials [7];
      int          r;
      specials = '{MN, MX, Z, P1, N1, 16'hFFFF, 16'h0001};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k])
         send_matrix({DIRECTED[k].m33, DIRECTED[k].m32, DIRECTED[k].m31,
                      DIRECTED[k].m23, DIRECTED[k].m22, DIRECTED[k].m21,
                      DIRECTED[k].m13, DIRECTED[k].m12, DIRECTED[k].m11},
                     DIRECTED[k].known, DIRECTED[k].q);

      for (int n = 0; n < RANDOM_MATRICES; n++) begin
         if (n % 150 == 0)
            gaps_on = ($urandom_range(0, 3) != 0);
         // Halfway through, hold off until the pipeline has fully drained.
         if (n == RANDOM_MATRICES / 2) begin
            req_tvalid <= 1'b0;
            while (quat_queue.size() != 0)
               @(posedge clock);
         end
         for (int i = 0; i < NUM_ELEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               e[i] = 16'($urandom_range(0, 65535));
            else
               e[i] = specials[$urandom_range(0, 6)];
         end
         // Mirror an off-diagonal pair now and then so its difference is zero.
         if ($urandom_range(0, 5) == 0) e[5] = e[7];
         if ($urandom_range(0, 5) == 0) e[6] = e[2];
         if ($urandom_range(0, 5) == 0) e[1] = e[3];
         send_matrix({e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]},
                     1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (quat_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d matrices (%0d from the table, the rest random).",
               matrices_sent, DIR_ROWS);
      $display("Checked %0d quaternions, %0d mismatches.", quats_checked,
               mismatch_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
